// File: rtl/lorenz_attractor_oscillator_macros.svh
// Assertion macros for the Lorenz oscillator checker.
// No dependencies; included by the checker file.
`ifndef LORENZ_ATTRACTOR_OSCILLATOR_MACROS_SVH
`define LORENZ_ATTRACTOR_OSCILLATOR_MACROS_SVH

// same-cycle implication
`define LAO_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LAO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/lao_pkg.sv
// Shared constants, register indexes and saturation helper for the
// Lorenz oscillator. No dependencies.
package lao_pkg;

   localparam int unsigned CSR_INDEX_W = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_SIGMA       = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RHO         = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BETA        = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_SIZE   = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_RATE = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_X     = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_Y     = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_Z     = 4'd7;

   localparam logic signed [31:0] RST_SIGMA   = 32'sd167772160;
   localparam logic signed [31:0] RST_RHO     = 32'sd469762048;
   localparam logic signed [31:0] RST_BETA    = 32'sd19573419;
   localparam logic [30:0]        RST_STEP    = 31'd838861;
   localparam logic [19:0]        RST_SRATE   = 20'd44100;
   localparam logic signed [31:0] RST_START_X = 32'sd1677722;
   localparam logic signed [31:0] RST_START_Y = 32'sd0;
   localparam logic signed [31:0] RST_START_Z = 32'sd0;

   localparam logic signed [31:0] PHASE_ONE = 32'sd1073741824;
   localparam logic signed [31:0] SIXTH_Q24 = 32'sd2796203;
   localparam logic signed [31:0] GAIN_Q32  = 32'sd171798692;

   function automatic logic signed [31:0] sat32(input logic signed [46:0] v);
      logic signed [31:0] r;
      if (v > 47'sd2147483647) r = 32'sh7fffffff;
      else if (v < -47'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// File: rtl/lorenz_attractor_oscillator.sv
// Lorenz oscillator: one RK4 step per phase wrap, interpolated x output.
// Shared 36x32 multiplier and a shared saturating adder under a microcoded sequencer.
// A request runs the divider (skipped when the step clips), the wrap check, an RK4 update on a wrap, then output.
// Requests: one at a time; the next can be taken while the response is
// presented. The bit-serial divider and the shared multiplier set the time per request.
// Synchronous reset loads default registers, start state and phase 1.0.
module lorenz_attractor_oscillator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [31:0]                req_freq_hz,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [23:0]                rsp_sample_out,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lao_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [31:0]                       csr_data
);
   import lao_pkg::*;

   typedef enum logic [3:0] {
      IDLE, DIV, WRAP, HS_MUL, HS_RND, STAGE, FINAL, OUTP, DONE
   } state_type;

   // stage micro-steps
   localparam logic [4:0] S_SUB_YX  = 5'd0;
   localparam logic [4:0] S_MUL_KX  = 5'd1;
   localparam logic [4:0] S_RND_KX  = 5'd2;
   localparam logic [4:0] S_SUB_RZ  = 5'd3;
   localparam logic [4:0] S_MUL_XT  = 5'd4;
   localparam logic [4:0] S_RND_XT  = 5'd5;
   localparam logic [4:0] S_SUB_TY  = 5'd6;
   localparam logic [4:0] S_MUL_KY  = 5'd7;
   localparam logic [4:0] S_RND_KY  = 5'd8;
   localparam logic [4:0] S_MUL_XY  = 5'd9;
   localparam logic [4:0] S_RND_XY  = 5'd10;
   localparam logic [4:0] S_MUL_BZ  = 5'd11;
   localparam logic [4:0] S_RND_BZ  = 5'd12;
   localparam logic [4:0] S_SUB_MT  = 5'd13;
   localparam logic [4:0] S_MUL_KZ  = 5'd14;
   localparam logic [4:0] S_RND_KZ  = 5'd15;
   localparam logic [4:0] S_ACC     = 5'd16;
   localparam logic [4:0] S_NEXT_X  = 5'd17;
   localparam logic [4:0] S_NEXT_Y  = 5'd18;
   localparam logic [4:0] S_NEXT_Z  = 5'd19;
   // final micro-steps
   localparam logic [4:0] F_MUL_X   = 5'd0;
   localparam logic [4:0] F_ADD_X   = 5'd1;
   localparam logic [4:0] F_MUL_Y   = 5'd2;
   localparam logic [4:0] F_ADD_Y   = 5'd3;
   localparam logic [4:0] F_MUL_Z   = 5'd4;
   localparam logic [4:0] F_ADD_Z   = 5'd5;
   localparam logic [4:0] F_DELTA   = 5'd6;
   // output micro-steps
   localparam logic [4:0] O_MUL_D   = 5'd0;
   localparam logic [4:0] O_ADD_S   = 5'd1;
   localparam logic [4:0] O_MUL_G   = 5'd2;
   localparam logic [4:0] O_RND     = 5'd3;

   localparam logic [4:0] DIV_STEPS = 5'd30;

   state_type state_ff, state_in;
   logic [4:0] pc_ff, pc_in;
   logic [1:0] stage_ff, stage_in;

   logic signed [31:0] sigma_ff, sigma_in, rho_ff, rho_in, beta_ff, beta_in;
   logic [30:0]        step_ff, step_in;
   logic [19:0]        srate_ff, srate_in;
   logic signed [31:0] stx_ff, stx_in, sty_ff, sty_in, stz_ff, stz_in;

   logic signed [31:0] x_ff, x_in, y_ff, y_in, z_ff, z_in, xd_ff, xd_in;
   logic signed [31:0] phase_ff, phase_in, pstep_ff, pstep_in;
   logic signed [31:0] xs_ff, xs_in, ys_ff, ys_in, zs_ff, zs_in;
   logic signed [31:0] hs_ff, hs_in, tmp_ff, tmp_in, m1_ff, m1_in, nx_ff, nx_in;
   logic signed [31:0] kx_ff, kx_in, ky_ff, ky_in, kz_ff, kz_in;
   logic signed [35:0] accx_ff, accx_in, accy_ff, accy_in, accz_ff, accz_in;
   logic signed [34:0] s_ff, s_in;
   logic signed [67:0] prod_ff, prod_in;

   logic               neg_ff, neg_in, clip_ff, clip_in;
   logic [19:0]        rem_ff, rem_in;
   logic [29:0]        dvd_ff, dvd_in, quo_ff, quo_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [23:0] out_ff, out_in;

   logic signed [35:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [45:0] add_a, add_b;
   logic signed [46:0] add_sum;
   logic signed [31:0] add_sat;
   logic signed [67:0] rnd_full;
   logic signed [31:0] rnd_sat;
   logic signed [43:0] rnd_wide;
   logic signed [31:0] h_s;
   logic signed [31:0] kcur, kpart;
   logic [19:0]        sr_eff;
   logic [31:0]        f_abs;
   logic [20:0]        trial;
   logic [30:0]        mag;
   logic signed [67:0] out_full;
   logic signed [31:0] out_wide;

   assign prod_in  = mul_a * mul_b;
   assign add_sum  = 47'(add_a) + 47'(add_b);
   assign add_sat  = sat32(add_sum);
   assign rnd_full = (prod_ff + 68'sd8388608) >>> 24;
   assign rnd_wide = rnd_full[43:0];
   assign rnd_sat  = sat32(47'(rnd_wide));
   assign h_s      = {1'b0, step_ff};
   assign sr_eff   = (srate_ff == 20'd0) ? 20'd1 : srate_ff;
   assign f_abs    = req_freq_hz[31] ? 32'(-33'(req_freq_hz)) : 32'(req_freq_hz);
   assign trial    = {rem_ff, dvd_ff[29]};
   assign mag      = clip_ff ? 31'h40000000 : {1'b0, quo_ff};
   assign out_full = (prod_ff + 68'sd34359738368) >>> 36;
   assign out_wide = out_full[31:0];

   always_comb begin
      unique case (stage_ff)
         2'd0, 2'd1: kcur = kx_ff;
         default:    kcur = kx_ff;
      endcase
      kpart = kcur;
   end

   always_comb begin
      state_in = state_ff; pc_in = pc_ff; stage_in = stage_ff;
      sigma_in = sigma_ff; rho_in = rho_ff; beta_in = beta_ff;
      step_in = step_ff; srate_in = srate_ff;
      stx_in = stx_ff; sty_in = sty_ff; stz_in = stz_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff; xd_in = xd_ff;
      phase_in = phase_ff; pstep_in = pstep_ff;
      xs_in = xs_ff; ys_in = ys_ff; zs_in = zs_ff;
      hs_in = hs_ff; tmp_in = tmp_ff; m1_in = m1_ff; nx_in = nx_ff;
      kx_in = kx_ff; ky_in = ky_ff; kz_in = kz_ff;
      accx_in = accx_ff; accy_in = accy_ff; accz_in = accz_ff;
      s_in = s_ff;
      neg_in = neg_ff; clip_in = clip_ff;
      rem_in = rem_ff; dvd_in = dvd_ff; quo_in = quo_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_in = out_ff;
      mul_a = '0; mul_b = '0; add_a = '0; add_b = '0;

      unique case (state_ff)
         IDLE: begin
            if (csr_valid) begin
               unique case (csr_index)
                  CSR_SIGMA:       sigma_in = csr_data;
                  CSR_RHO:         rho_in = csr_data;
                  CSR_BETA:        beta_in = csr_data;
                  CSR_STEP_SIZE:   step_in = csr_data[30:0];
                  CSR_SAMPLE_RATE: srate_in = csr_data[19:0];
                  CSR_START_X:     stx_in = csr_data;
                  CSR_START_Y:     sty_in = csr_data;
                  CSR_START_Z:     stz_in = csr_data;
                  default: ;
               endcase
               if (csr_index <= CSR_START_Z) begin
                  x_in = (csr_index == CSR_START_X) ? csr_data : stx_ff;
                  y_in = (csr_index == CSR_START_Y) ? csr_data : sty_ff;
                  z_in = (csr_index == CSR_START_Z) ? csr_data : stz_ff;
               end
            end else if (req_valid) begin
               neg_in  = req_freq_hz[31];
               clip_in = f_abs >= {4'd0, sr_eff, 8'd0};
               rem_in  = f_abs[27:8];
               dvd_in  = {f_abs[7:0], 22'd0};
               quo_in  = '0;
               pc_in   = '0;
               state_in = (f_abs >= {4'd0, sr_eff, 8'd0}) ? WRAP : DIV;
            end
         end
         DIV: begin
            if (trial >= {1'b0, sr_eff}) begin
               rem_in = 20'(trial - {1'b0, sr_eff});
               quo_in = {quo_ff[28:0], 1'b1};
            end else begin
               rem_in = trial[19:0];
               quo_in = {quo_ff[28:0], 1'b0};
            end
            dvd_in = {dvd_ff[28:0], 1'b0};
            pc_in = pc_ff + 5'd1;
            if (pc_ff == DIV_STEPS - 5'd1) state_in = WRAP;
         end
         WRAP: begin
            pstep_in = neg_ff ? 32'(-32'sd0 - 32'(mag)) : 32'(mag);
            pc_in = '0;
            stage_in = '0;
            if (!neg_ff && phase_ff >= PHASE_ONE) begin
               phase_in = phase_ff - PHASE_ONE;
               state_in = HS_MUL;
            end else if (neg_ff && phase_ff <= 32'sd0) begin
               phase_in = phase_ff + PHASE_ONE;
               state_in = HS_MUL;
            end else begin
               state_in = OUTP;
            end
         end
         HS_MUL: begin
            mul_a = 36'(h_s); mul_b = sigma_ff;
            xs_in = x_ff; ys_in = y_ff; zs_in = z_ff;
            accx_in = '0; accy_in = '0; accz_in = '0;
            state_in = HS_RND;
         end
         HS_RND: begin
            hs_in = rnd_sat;
            state_in = STAGE;
         end
         STAGE: begin
            pc_in = pc_ff + 5'd1;
            unique case (pc_ff)
               S_SUB_YX: begin add_a = 46'(ys_ff); add_b = -46'(xs_ff); tmp_in = add_sat; end
               S_MUL_KX: begin mul_a = 36'(hs_ff); mul_b = tmp_ff; end
               S_RND_KX: kx_in = rnd_sat;
               S_SUB_RZ: begin add_a = 46'(rho_ff); add_b = -46'(zs_ff); tmp_in = add_sat; end
               S_MUL_XT: begin mul_a = 36'(xs_ff); mul_b = tmp_ff; end
               S_RND_XT: tmp_in = rnd_sat;
               S_SUB_TY: begin add_a = 46'(tmp_ff); add_b = -46'(ys_ff); tmp_in = add_sat; end
               S_MUL_KY: begin mul_a = 36'(h_s); mul_b = tmp_ff; end
               S_RND_KY: ky_in = rnd_sat;
               S_MUL_XY: begin mul_a = 36'(xs_ff); mul_b = ys_ff; end
               S_RND_XY: m1_in = rnd_sat;
               S_MUL_BZ: begin mul_a = 36'(beta_ff); mul_b = zs_ff; end
               S_RND_BZ: tmp_in = rnd_sat;
               S_SUB_MT: begin add_a = 46'(m1_ff); add_b = -46'(tmp_ff); tmp_in = add_sat; end
               S_MUL_KZ: begin mul_a = 36'(h_s); mul_b = tmp_ff; end
               S_RND_KZ: kz_in = rnd_sat;
               S_ACC: begin
                  if (stage_ff == 2'd1 || stage_ff == 2'd2) begin
                     accx_in = accx_ff + (36'(kx_ff) <<< 1);
                     accy_in = accy_ff + (36'(ky_ff) <<< 1);
                     accz_in = accz_ff + (36'(kz_ff) <<< 1);
                  end else begin
                     accx_in = accx_ff + 36'(kx_ff);
                     accy_in = accy_ff + 36'(ky_ff);
                     accz_in = accz_ff + 36'(kz_ff);
                  end
                  if (stage_ff == 2'd3) begin
                     state_in = FINAL;
                     pc_in = '0;
                  end
               end
               S_NEXT_X: begin
                  add_a = 46'(x_ff);
                  add_b = (stage_ff == 2'd2) ? 46'(kpart) : 46'(kpart >>> 1);
                  xs_in = add_sat;
               end
               S_NEXT_Y: begin
                  add_a = 46'(y_ff);
                  add_b = (stage_ff == 2'd2) ? 46'(ky_ff) : 46'(ky_ff >>> 1);
                  ys_in = add_sat;
               end
               S_NEXT_Z: begin
                  add_a = 46'(z_ff);
                  add_b = (stage_ff == 2'd2) ? 46'(kz_ff) : 46'(kz_ff >>> 1);
                  zs_in = add_sat;
                  stage_in = stage_ff + 2'd1;
                  pc_in = '0;
               end
               default: pc_in = '0;
            endcase
         end
         FINAL: begin
            pc_in = pc_ff + 5'd1;
            unique case (pc_ff)
               F_MUL_X: begin mul_a = accx_ff; mul_b = SIXTH_Q24; end
               F_ADD_X: begin add_a = 46'(x_ff); add_b = 46'(rnd_wide); nx_in = add_sat; end
               F_MUL_Y: begin mul_a = accy_ff; mul_b = SIXTH_Q24; end
               F_ADD_Y: begin add_a = 46'(y_ff); add_b = 46'(rnd_wide); y_in = add_sat; end
               F_MUL_Z: begin mul_a = accz_ff; mul_b = SIXTH_Q24; end
               F_ADD_Z: begin add_a = 46'(z_ff); add_b = 46'(rnd_wide); z_in = add_sat; end
               F_DELTA: begin
                  add_a = 46'(nx_ff); add_b = -46'(x_ff);
                  xd_in = add_sat;
                  x_in = nx_ff;
                  pc_in = '0;
                  state_in = OUTP;
               end
               default: pc_in = '0;
            endcase
         end
         OUTP: begin
            pc_in = pc_ff + 5'd1;
            unique case (pc_ff)
               O_MUL_D: begin mul_a = 36'(xd_ff); mul_b = phase_ff; end
               O_ADD_S: begin
                  add_a = 46'(x_ff); add_b = 46'(prod_ff >>> 30);
                  s_in = add_sum[34:0];
               end
               O_MUL_G: begin
                  mul_a = 36'(s_ff); mul_b = GAIN_Q32;
                  // keep the previous response until it is taken
                  if (rsp_valid_ff && rsp_stall) pc_in = pc_ff;
               end
               O_RND: begin
                  if (out_wide > 32'sd8388607) out_in = 24'sh7fffff;
                  else if (out_wide < -32'sd8388608) out_in = 24'sh800000;
                  else out_in = out_wide[23:0];
                  add_a = 46'(phase_ff); add_b = 46'(pstep_ff);
                  phase_in = add_sat;
                  state_in = DONE;
               end
               default: pc_in = '0;
            endcase
         end
         DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE; pc_ff <= '0; stage_ff <= '0;
         sigma_ff <= RST_SIGMA; rho_ff <= RST_RHO; beta_ff <= RST_BETA;
         step_ff <= RST_STEP; srate_ff <= RST_SRATE;
         stx_ff <= RST_START_X; sty_ff <= RST_START_Y; stz_ff <= RST_START_Z;
         x_ff <= RST_START_X; y_ff <= RST_START_Y; z_ff <= RST_START_Z;
         xd_ff <= '0; phase_ff <= PHASE_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; pc_ff <= pc_in; stage_ff <= stage_in;
         sigma_ff <= sigma_in; rho_ff <= rho_in; beta_ff <= beta_in;
         step_ff <= step_in; srate_ff <= srate_in;
         stx_ff <= stx_in; sty_ff <= sty_in; stz_ff <= stz_in;
         x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
         xd_ff <= xd_in; phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pstep_ff <= pstep_in;
      xs_ff <= xs_in; ys_ff <= ys_in; zs_ff <= zs_in;
      hs_ff <= hs_in; tmp_ff <= tmp_in; m1_ff <= m1_in; nx_ff <= nx_in;
      kx_ff <= kx_in; ky_ff <= ky_in; kz_ff <= kz_in;
      accx_ff <= accx_in; accy_ff <= accy_in; accz_ff <= accz_in;
      s_ff <= s_in; prod_ff <= prod_in;
      neg_ff <= neg_in; clip_ff <= clip_in;
      rem_ff <= rem_in; dvd_ff <= dvd_in; quo_ff <= quo_in;
      out_ff <= out_in;
   end

   assign req_stall      = (state_ff != IDLE) || csr_valid;
   assign csr_ready      = (state_ff == IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = out_ff;

endmodule

// File: rtl/lao_checker.sv
// Port-level checker for the Lorenz oscillator, bound to the top level.
// Depends on lao_pkg and the assertion macro header.
`include "lorenz_attractor_oscillator_macros.svh"
module lao_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic signed [23:0]              rsp_sample_out,
   input logic                            csr_valid,
   input logic                            csr_ready
);
   import lao_pkg::*;

   `LAO_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_sample_out), "stalled response changed")
   `LAO_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall && !csr_ready, "request accepted but block not busy")
   `LAO_ASSERT_NOW(a_cfg_only_idle, clock, reset, csr_ready && !csr_valid, !req_stall, "idle block refused request")
   `LAO_ASSERT_NEXT(a_no_rsp_after_reset, clock, 1'b0, reset, !rsp_valid, "response valid after reset")

endmodule

bind lorenz_attractor_oscillator lao_checker u_lao_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_sample_out(rsp_sample_out),
   .csr_valid(csr_valid), .csr_ready(csr_ready)
);

// File: dv/lorenz_attractor_oscillator_test.sv
// Self-checking test for lorenz_attractor_oscillator: random and directed requests,
// register writes between phases, and a cycle-accurate-free predictor of each sample.
// Depends on rtl/lao_pkg.sv and rtl/lorenz_attractor_oscillator.sv.
module lorenz_attractor_oscillator_test;
   timeunit 1ns;
   timeprecision 1ps;
   import lao_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 150;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_freq_hz = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [23:0] rsp_sample_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   lorenz_attractor_oscillator DUT (.*);

   always #1 clock = ~clock;

   // predictor state
   logic signed [31:0] sigma_q, rho_q, beta_q, start_x_q, start_y_q, start_z_q;
   logic [30:0] step_q;
   logic [19:0] rate_q;
   logic signed [31:0] pos_x, pos_y, pos_z, x_delta, phase_acc;

   logic signed [31:0] pending_freqs[$];
   logic signed [23:0] expected_samples[$];
   logic signed [31:0] corner_freqs[14] = '{32'sd0, 32'sh7fffffff, 32'sh80000000, -32'sd1,
      32'sd1, 32'sd11289600, -32'sd11289600, 32'sd11289600, 32'sd5000000, -32'sd256,
      32'sd1000000, 32'sh55555555, 32'shaaaaaaaa, 32'sd0};
   bit   idle_on = 1'b0;
   logic req_fire = 1'b0;
   int   n_req = 0, n_rsp = 0, n_wraps = 0, n_csr = 0, n_bad = 0, quiet = 0;

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint sat(longint v);
      return clip(v, -64'sd2147483648, 64'sd2147483647);
   endfunction

   function automatic longint qmul(longint a, longint b);
      return sat((a * b + 64'sd8388608) >>> 24);
   endfunction

   function automatic void lorenz_slope(input longint hs, x, y, z,
                                        output longint kx, ky, kz);
      longint h;
      h  = longint'(step_q);
      kx = qmul(hs, sat(y - x));
      ky = qmul(h, sat(qmul(x, sat(longint'(rho_q) - z)) - y));
      kz = qmul(h, sat(qmul(x, y) - qmul(longint'(beta_q), z)));
   endfunction

   function automatic longint rk_blend(longint v, k1, k2, k3, k4);
      longint s;
      s = k1 + 2 * (k2 + k3) + k4;
      return sat(v + ((s * 64'sd2796203 + 64'sd8388608) >>> 24));
   endfunction

   function automatic void rk4_update();
      longint hs, x, y, z, nx;
      longint k1x, k1y, k1z, k2x, k2y, k2z, k3x, k3y, k3z, k4x, k4y, k4z;
      hs = qmul(longint'(step_q), longint'(sigma_q));
      x = pos_x; y = pos_y; z = pos_z;
      lorenz_slope(hs, x, y, z, k1x, k1y, k1z);
      lorenz_slope(hs, sat(x + (k1x >>> 1)), sat(y + (k1y >>> 1)), sat(z + (k1z >>> 1)),
                   k2x, k2y, k2z);
      lorenz_slope(hs, sat(x + (k2x >>> 1)), sat(y + (k2y >>> 1)), sat(z + (k2z >>> 1)),
                   k3x, k3y, k3z);
      lorenz_slope(hs, sat(x + k3x), sat(y + k3y), sat(z + k3z), k4x, k4y, k4z);
      nx = rk_blend(x, k1x, k2x, k3x, k4x);
      pos_y = 32'(rk_blend(y, k1y, k2y, k3y, k4y));
      pos_z = 32'(rk_blend(z, k1z, k2z, k3z, k4z));
      x_delta = 32'(sat(nx - x));
      pos_x = 32'(nx);
      n_wraps++;
   endfunction

   function automatic logic signed [23:0] predict_sample(logic signed [31:0] freq);
      longint f, sr, pstep, ph, s, r;
      bit wrap;
      f  = freq;
      sr = rate_q != 0 ? longint'(rate_q) : 1;
      pstep = clip((f * 64'sd4194304) / sr, -64'sd1073741824, 64'sd1073741824);
      ph = phase_acc;
      if (f >= 0) begin
         wrap = ph >= 64'sd1073741824;
         if (wrap) ph -= 64'sd1073741824;
      end else begin
         wrap = ph <= 0;
         if (wrap) ph += 64'sd1073741824;
      end
      if (wrap) rk4_update();
      s = longint'(pos_x) + ((longint'(x_delta) * ph) >>> 30);
      r = clip((s * 64'sd171798692 + 64'sd34359738368) >>> 36, -64'sd8388608, 64'sd8388607);
      phase_acc = 32'(sat(ph + pstep));
      return 24'(r);
   endfunction

   function automatic void regs_default();
      sigma_q = RST_SIGMA; rho_q = RST_RHO; beta_q = RST_BETA;
      step_q = RST_STEP; rate_q = RST_SRATE;
      start_x_q = RST_START_X; start_y_q = RST_START_Y; start_z_q = RST_START_Z;
      pos_x = start_x_q; pos_y = start_y_q; pos_z = start_z_q;
      x_delta = '0; phase_acc = PHASE_ONE;
   endfunction

   function automatic void apply_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] d);
      case (idx)
         CSR_SIGMA:       sigma_q = d;
         CSR_RHO:         rho_q = d;
         CSR_BETA:        beta_q = d;
         CSR_STEP_SIZE:   step_q = d[30:0];
         CSR_SAMPLE_RATE: rate_q = d[19:0];
         CSR_START_X:     start_x_q = d;
         CSR_START_Y:     start_y_q = d;
         CSR_START_Z:     start_z_q = d;
         default:         return;
      endcase
      pos_x = start_x_q; pos_y = start_y_q; pos_z = start_z_q;
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fire)) begin
         if (pending_freqs.size() > 0 && !(idle_on && $urandom_range(0, 99) < 9)) begin
            req_valid   <= 1'b1;
            req_freq_hz <= pending_freqs.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= idle_on && ($urandom_range(0, 99) < 9);
   end

   // monitor, scoreboard and watchdog
   always @(posedge clock) begin
      logic signed [23:0] want;
      bit active;
      active = 1'b0;
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_samples.push_back(predict_sample(req_freq_hz));
            n_req++;
            active = 1'b1;
         end
         if (csr_valid && csr_ready) active = 1'b1;
         if (rsp_valid && !rsp_stall) begin
            active = 1'b1;
            n_rsp++;
            if (expected_samples.size() == 0) begin
               n_bad++;
               if (n_bad <= 10) $display("unexpected sample %0d", rsp_sample_out);
            end else begin
               want = expected_samples.pop_front();
               if (want !== rsp_sample_out) begin
                  n_bad++;
                  if (n_bad <= 10)
                     $display("sample_out mismatch: expected %0d got %0d", want,
                              rsp_sample_out);
               end
            end
         end
         quiet <= active ? 0 : quiet + 1;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic drain();
      do @(negedge clock);
      while (pending_freqs.size() != 0 || expected_samples.size() != 0 || req_valid);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] d);
      @(negedge clock);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, d);
      n_csr++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [31:0] audio_freq();
      logic signed [31:0] f;
      f = $urandom_range(0, 6000000);
      if ($urandom_range(0, 99) < 70) return f;
      if ($urandom_range(0, 1)) return -f;
      return $urandom();
   endfunction

   task automatic random_run(int n);
      repeat (n) pending_freqs.push_back(audio_freq());
   endtask

   initial begin
      regs_default();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // defaults: zero, extremes, exact unit step, sign flips
      idle_on = 1'b1;
      foreach (corner_freqs[i]) pending_freqs.push_back(corner_freqs[i]);
      random_run(40);
      drain();

      // saturating extremes
      write_reg(CSR_SIGMA, 32'h7fffffff);
      write_reg(CSR_RHO, 32'h80000000);
      write_reg(CSR_BETA, 32'h7fffffff);
      write_reg(CSR_STEP_SIZE, 32'hffffffff);
      write_reg(CSR_SAMPLE_RATE, 32'h00000001);
      write_reg(CSR_START_X, 32'h7fffffff);
      write_reg(CSR_START_Y, 32'h80000000);
      write_reg(CSR_START_Z, 32'h7fffffff);
      pending_freqs.push_back(32'sh7fffffff);
      pending_freqs.push_back(32'sh80000000);
      random_run(40);
      drain();

      // zero sample rate, out-of-range index, opposite extremes
      write_reg(CSR_SAMPLE_RATE, 32'hfff00000);
      write_reg(4'd15, $urandom());
      write_reg(CSR_SIGMA, 32'h80000000);
      write_reg(CSR_BETA, 32'h80000000);
      write_reg(CSR_STEP_SIZE, 32'h0);
      write_reg(CSR_START_X, 32'h80000000);
      random_run(40);
      drain();

      // back to audio settings, long stretch with no idling
      write_reg(CSR_SIGMA, 32'(RST_SIGMA));
      write_reg(CSR_RHO, 32'(RST_RHO));
      write_reg(CSR_BETA, 32'(RST_BETA));
      write_reg(CSR_STEP_SIZE, {1'b0, RST_STEP});
      write_reg(CSR_SAMPLE_RATE, 32'd8000);
      write_reg(CSR_START_X, $urandom_range(0, 33554432));
      write_reg(CSR_START_Y, -$urandom_range(0, 33554432));
      write_reg(CSR_START_Z, $urandom_range(0, 33554432));
      idle_on = 1'b0;
      random_run(150);
      drain();

      idle_on = 1'b1;
      write_reg(CSR_SAMPLE_RATE, $urandom_range(8000, 768000));
      write_reg(CSR_STEP_SIZE, $urandom_range(0, 4000000));
      random_run(230);
      drain();

      $display("%0d requests, %0d samples, %0d RK4 updates, %0d register writes",
               n_req, n_rsp, n_wraps, n_csr);
      $display("%0d mismatches", n_bad);
      if (n_bad == 0 && expected_samples.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

// File: sim.f
+incdir+rtl
rtl/lao_pkg.sv
rtl/lorenz_attractor_oscillator.sv
rtl/lao_checker.sv
dv/lorenz_attractor_oscillator_test.sv
